@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms. Define NO_ASSERTIONS to drop them.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPLIES(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, cond, prop)
`define ASSERT_NEXT(label, clk, rst, cond, prop)
`endif
`endif

@@ rtl/sels_pkg.sv @@
// ----------------------------------------------------------------------------
// sels_pkg
// Types and constants of the segment subdivision unit.
// ----------------------------------------------------------------------------
package sels_pkg;
   localparam int COORD_W    = 24;
   localparam int STEP_W     = 23;
   localparam int MAG_W      = 24;
   localparam int SQ_W       = 50;
   localparam int ROOT_W     = 25;
   localparam int REM_W      = 28;
   localparam int PROD_W     = ROOT_W + MAG_W;
   localparam int IDX_W      = 6;
   localparam int MAX_PIECES = 64;
   localparam int CNT_W      = $clog2(MAX_PIECES);
   localparam int ITER_W     = 6;
   localparam logic [STEP_W-1:0] STEP_RESET = 23'd399;

   typedef struct packed {
      logic signed [COORD_W-1:0] start_x;
      logic signed [COORD_W-1:0] start_y;
      logic signed [COORD_W-1:0] end_x;
      logic signed [COORD_W-1:0] end_y;
   } req_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] piece_start_x;
      logic signed [COORD_W-1:0] piece_start_y;
      logic signed [COORD_W-1:0] piece_end_x;
      logic signed [COORD_W-1:0] piece_end_y;
      logic [IDX_W-1:0]          piece_index;
      logic                      last_piece;
      logic                      truncated;
   } rsp_type;

   typedef struct packed {
      req_type             seg;
      logic                neg_x;
      logic                neg_y;
      logic [MAG_W-1:0]    mag_x;
      logic [MAG_W-1:0]    mag_y;
      logic [ROOT_W-1:0]   seg_len;
      logic [STEP_W-1:0]   step;
      logic [CNT_W-1:0]    count;
      logic                extra;
      logic                capped;
      logic                single;
   } job_type;
endpackage

@@ rtl/sels_front.sv @@
// ----------------------------------------------------------------------------
// sels_front
// Takes a segment, finds its integer length and the piece count.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module sels_front (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  sels_pkg::req_type              req_data,
   input  logic [sels_pkg::STEP_W-1:0]    step_length,
   input  logic                           q_full,
   output logic                           q_push,
   output sels_pkg::job_type              q_job
);
   import sels_pkg::*;

   typedef enum logic [5:0] {
      F_IDLE = 6'b000001,
      F_SQX  = 6'b000010,
      F_SQY  = 6'b000100,
      F_SQRT = 6'b001000,
      F_DIV  = 6'b010000,
      F_PUSH = 6'b100000
   } front_state_type;

   front_state_type     state_ff, state_in;
   job_type             job_ff, job_in;
   logic [SQ_W-1:0]     sum_ff, sum_in;
   logic [REM_W-1:0]    rem_ff, rem_in;
   logic [ROOT_W-1:0]   root_ff, root_in;
   logic [ITER_W-1:0]   iter_ff, iter_in;
   logic [MAG_W-1:0]    mul_op;
   logic [2*MAG_W-1:0]  sq;
   logic [REM_W-1:0]    rem_sh, trial;
   logic [STEP_W:0]     drem_sh;
   logic signed [COORD_W:0] dx, dy;

   assign busy   = (state_ff != F_IDLE);
   assign q_push = (state_ff == F_PUSH) && !q_full;
   assign q_job  = job_ff;

   always_comb begin
      state_in = state_ff;
      job_in   = job_ff;
      sum_in   = sum_ff;
      rem_in   = rem_ff;
      root_in  = root_ff;
      iter_in  = iter_ff;
      dx = {job_ff.seg.end_x[COORD_W-1], job_ff.seg.end_x}
         - {job_ff.seg.start_x[COORD_W-1], job_ff.seg.start_x};
      dy = {job_ff.seg.end_y[COORD_W-1], job_ff.seg.end_y}
         - {job_ff.seg.start_y[COORD_W-1], job_ff.seg.start_y};
      // Magnitudes are not yet registered in the first squaring cycle.
      mul_op  = (state_ff == F_SQX) ? (dx[COORD_W] ? MAG_W'(-dx) : MAG_W'(dx))
                                    : job_ff.mag_y;
      sq      = mul_op * mul_op;
      rem_sh  = {rem_ff[REM_W-3:0], sum_ff[SQ_W-1 -: 2]};
      trial   = {1'b0, root_ff, 2'b01};
      drem_sh = {rem_ff[STEP_W-1:0], root_ff[ROOT_W-1]};
      case (state_ff)
         F_IDLE: begin
            if (start) begin
               job_in.seg  = req_data;
               job_in.step = step_length;
               state_in    = F_SQX;
            end
         end
         F_SQX: begin
            job_in.neg_x = dx[COORD_W];
            job_in.neg_y = dy[COORD_W];
            job_in.mag_x = dx[COORD_W] ? MAG_W'(-dx) : MAG_W'(dx);
            job_in.mag_y = dy[COORD_W] ? MAG_W'(-dy) : MAG_W'(dy);
            sum_in   = SQ_W'(sq);
            state_in = F_SQY;
         end
         F_SQY: begin
            sum_in   = sum_ff + SQ_W'(sq);
            rem_in   = '0;
            root_in  = '0;
            iter_in  = ITER_W'(ROOT_W - 1);
            state_in = F_SQRT;
         end
         F_SQRT: begin
            sum_in = {sum_ff[SQ_W-3:0], 2'b00};
            if (rem_sh >= trial) begin
               rem_in  = rem_sh - trial;
               root_in = {root_ff[ROOT_W-2:0], 1'b1};
            end else begin
               rem_in  = rem_sh;
               root_in = {root_ff[ROOT_W-2:0], 1'b0};
            end
            iter_in = iter_ff - 1'b1;
            if (iter_ff == '0) begin
               job_in.seg_len = root_in;
               rem_in         = '0;
               iter_in        = ITER_W'(ROOT_W - 1);
               state_in       = F_DIV;
            end
         end
         F_DIV: begin
            // root_ff now shifts out the length, and sum_ff gathers the quotient.
            root_in = {root_ff[ROOT_W-2:0], 1'b0};
            if (drem_sh >= {1'b0, job_ff.step}) begin
               rem_in = REM_W'(drem_sh - {1'b0, job_ff.step});
               sum_in = {sum_ff[SQ_W-2:0], 1'b1};
            end else begin
               rem_in = REM_W'(drem_sh);
               sum_in = {sum_ff[SQ_W-2:0], 1'b0};
            end
            iter_in = iter_ff - 1'b1;
            if (iter_ff == '0) begin
               job_in.single = (job_ff.step == '0) || (sum_in[ROOT_W-1:0] == '0);
               job_in.capped = sum_in[ROOT_W-1:0] > ROOT_W'(MAX_PIECES - 1);
               job_in.extra  = (rem_in != '0) || job_in.capped;
               job_in.count  = job_in.capped ? CNT_W'(MAX_PIECES - 1)
                                             : sum_in[CNT_W-1:0];
               state_in      = F_PUSH;
            end
         end
         F_PUSH: begin
            if (!q_full) begin
               state_in = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
      if (state_ff == F_SQRT && iter_ff == '0) begin
         sum_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
      job_ff  <= job_in;
      sum_ff  <= sum_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      iter_ff <= iter_in;
   end

   `ASSERT_IMPLIES(a_push_room, clock, reset, q_push, !q_full)
   `ASSERT_IMPLIES(a_busy_hold, clock, reset, busy && start, state_ff != F_IDLE)
   `ASSERT_NEXT(a_accept_seq, clock, reset, !busy && start, state_ff == F_SQX)
endmodule

@@ rtl/sels_queue.sv @@
// ----------------------------------------------------------------------------
// sels_queue
// Two-entry queue of classified segments between front and back.
// ----------------------------------------------------------------------------
module sels_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  sels_pkg::job_type         wr_job,
   input  logic                      pop,
   output sels_pkg::job_type         rd_job,
   output logic                      valid,
   output logic                      full
);
   import sels_pkg::*;

   job_type      entry_ff [2];
   logic         wr_ptr_ff, rd_ptr_ff;
   logic [1:0]   count_ff;

   assign rd_job = entry_ff[rd_ptr_ff];
   assign valid  = (count_ff != 2'd0);
   assign full   = (count_ff == 2'd2);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         count_ff <= count_ff + {1'b0, push} - {1'b0, pop};
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= wr_job;
      end
   end
endmodule

@@ rtl/sels_back.sv @@
// ----------------------------------------------------------------------------
// sels_back
// Walks the pieces of one segment and interpolates their endpoints.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module sels_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   q_valid,
   input  sels_pkg::job_type      q_job,
   output logic                   q_pop,
   output logic                   rsp_strobe,
   output sels_pkg::rsp_type      rsp_data
);
   import sels_pkg::*;

   typedef enum logic [4:0] {
      B_IDLE = 5'b00001,
      B_MUL  = 5'b00010,
      B_DIV  = 5'b00100,
      B_EMIT = 5'b01000,
      B_TAIL = 5'b10000
   } back_state_type;

   back_state_type              state_ff, state_in;
   job_type                     job_ff;
   logic signed [COORD_W-1:0]   px_ff, py_ff, nx, ny;
   logic [CNT_W-1:0]            idx_ff;
   logic [ROOT_W-1:0]           k_ff;
   logic [PROD_W-1:0]           numx_ff, numy_ff;
   logic [ROOT_W-1:0]           remx_ff, remy_ff, qx_ff, qy_ff;
   logic [ROOT_W:0]             remx_sh, remy_sh;
   logic [ITER_W-1:0]           iter_ff;
   logic                        valid_ff;
   rsp_type                     rsp_ff;
   logic                        last_cnt;

   assign q_pop      = (state_ff == B_IDLE) && q_valid;
   assign rsp_strobe = valid_ff;
   assign rsp_data   = rsp_ff;
   assign remx_sh    = {remx_ff, numx_ff[PROD_W-1]};
   assign remy_sh    = {remy_ff, numy_ff[PROD_W-1]};
   assign nx = job_ff.neg_x ? job_ff.seg.start_x - $signed(qx_ff[COORD_W-1:0])
                            : job_ff.seg.start_x + $signed(qx_ff[COORD_W-1:0]);
   assign ny = job_ff.neg_y ? job_ff.seg.start_y - $signed(qy_ff[COORD_W-1:0])
                            : job_ff.seg.start_y + $signed(qy_ff[COORD_W-1:0]);
   assign last_cnt = (idx_ff == job_ff.count - 1'b1);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         B_IDLE: begin
            if (q_valid) begin
               state_in = q_job.single ? B_TAIL : B_MUL;
            end
         end
         B_MUL:  state_in = B_DIV;
         B_DIV:  state_in = (iter_ff == '0) ? B_EMIT : B_DIV;
         B_EMIT: begin
            if (!last_cnt) begin
               state_in = B_MUL;
            end else begin
               state_in = job_ff.extra ? B_TAIL : B_IDLE;
            end
         end
         B_TAIL: state_in = B_IDLE;
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= (state_ff == B_EMIT) || (state_ff == B_TAIL);
      end
      case (state_ff)
         B_IDLE: begin
            job_ff <= q_job;
            px_ff  <= q_job.seg.start_x;
            py_ff  <= q_job.seg.start_y;
            idx_ff <= '0;
            k_ff   <= ROOT_W'(q_job.step);
         end
         B_MUL: begin
            numx_ff <= k_ff * job_ff.mag_x;
            numy_ff <= k_ff * job_ff.mag_y;
            remx_ff <= '0;
            remy_ff <= '0;
            iter_ff <= ITER_W'(PROD_W - 1);
         end
         B_DIV: begin
            numx_ff <= {numx_ff[PROD_W-2:0], 1'b0};
            numy_ff <= {numy_ff[PROD_W-2:0], 1'b0};
            if (remx_sh >= {1'b0, job_ff.seg_len}) begin
               remx_ff <= ROOT_W'(remx_sh - {1'b0, job_ff.seg_len});
               qx_ff   <= {qx_ff[ROOT_W-2:0], 1'b1};
            end else begin
               remx_ff <= remx_sh[ROOT_W-1:0];
               qx_ff   <= {qx_ff[ROOT_W-2:0], 1'b0};
            end
            if (remy_sh >= {1'b0, job_ff.seg_len}) begin
               remy_ff <= ROOT_W'(remy_sh - {1'b0, job_ff.seg_len});
               qy_ff   <= {qy_ff[ROOT_W-2:0], 1'b1};
            end else begin
               remy_ff <= remy_sh[ROOT_W-1:0];
               qy_ff   <= {qy_ff[ROOT_W-2:0], 1'b0};
            end
            iter_ff <= iter_ff - 1'b1;
         end
         B_EMIT: begin
            rsp_ff.piece_start_x <= px_ff;
            rsp_ff.piece_start_y <= py_ff;
            rsp_ff.piece_end_x   <= nx;
            rsp_ff.piece_end_y   <= ny;
            rsp_ff.piece_index   <= IDX_W'(idx_ff);
            rsp_ff.last_piece    <= last_cnt && !job_ff.extra;
            rsp_ff.truncated     <= job_ff.capped;
            px_ff  <= nx;
            py_ff  <= ny;
            idx_ff <= idx_ff + 1'b1;
            k_ff   <= k_ff + ROOT_W'(job_ff.step);
         end
         B_TAIL: begin
            rsp_ff.piece_start_x <= px_ff;
            rsp_ff.piece_start_y <= py_ff;
            rsp_ff.piece_end_x   <= job_ff.seg.end_x;
            rsp_ff.piece_end_y   <= job_ff.seg.end_y;
            rsp_ff.piece_index   <= IDX_W'(idx_ff);
            rsp_ff.last_piece    <= 1'b1;
            rsp_ff.truncated     <= job_ff.capped && !job_ff.single;
         end
         default: ;
      endcase
   end

   `ASSERT_NEXT(a_gap_after_last, clock, reset, rsp_strobe && rsp_data.last_piece, !rsp_strobe)
   `ASSERT_IMPLIES(a_pop_has_item, clock, reset, q_pop, q_valid)
   `ASSERT_NEXT(a_single_alone, clock, reset,
      (state_ff == B_IDLE) && q_valid && q_job.single, state_ff == B_TAIL)
endmodule

@@ rtl/segment_equal_length_split_unit.sv @@
// ----------------------------------------------------------------------------
// segment_equal_length_split_unit
// Splits a segment into pieces of equal length, with a final remainder piece when one is left over.
// ----------------------------------------------------------------------------
// A segment is taken when start is high and busy is low. The front end forms
// the squared length, then runs a 25-step square root and a 25-step count
// division; busy stays high for that time and while the two-entry queue is
// full. The back end takes a segment from the queue, works out each equal
// piece with a 49-step restoring division run on both axes at once, and
// then emits the remainder piece, if there is one.
// Pieces appear on rsp_data for one cycle each, marked by rsp_strobe; the
// receiver must take every piece as it comes.
module segment_equal_length_split_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  sels_pkg::req_type              req_data,
   output logic                           rsp_strobe,
   output sels_pkg::rsp_type              rsp_data,
   input  logic                           csr_wr_en,
   input  logic [sels_pkg::STEP_W-1:0]    csr_wr_data
);
   import sels_pkg::*;

   logic [STEP_W-1:0]  step_ff;
   logic               q_push, q_pop, q_valid, q_full;
   job_type            push_job, pop_job;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_RESET;
      end else if (csr_wr_en) begin
         step_ff <= csr_wr_data;
      end
   end

   sels_front u_front (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_data    (req_data),
      .step_length (step_ff),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_job       (push_job)
   );

   sels_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (q_push),
      .wr_job (push_job),
      .pop    (q_pop),
      .rd_job (pop_job),
      .valid  (q_valid),
      .full   (q_full)
   );

   sels_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_job      (pop_job),
      .q_pop      (q_pop),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );
endmodule
